@@ rtl/led_blink_pattern_sequencer_unit_macros.svh @@
// Assertion macros for the LED blink pattern sequencer, used by its pattern engine.
`ifndef LED_BLINK_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define LED_BLINK_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define LBPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbps assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define LBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbps assertion failed");

`endif

@@ rtl/lbps_pkg.sv @@
// Package with the types, pattern codes and step table of the LED blink sequencer.
package lbps_pkg;

    // Width of the tick counter that the due time is kept in.
    localparam int TICK_BITS = 32;
    localparam int NOW_BITS  = 32;

    // Pattern codes.
    localparam logic [2:0] PAT_KEEP_OFF = 3'd0;
    localparam logic [2:0] PAT_KEEP_ON  = 3'd1;
    localparam logic [2:0] PAT_DOUBLE   = 3'd2;
    localparam logic [2:0] PAT_FAST     = 3'd3;
    localparam logic [2:0] PAT_SLOW     = 3'd4;
    localparam logic [2:0] PAT_ONCE     = 3'd5;

    // Item modes.
    localparam logic MODE_SELECT  = 1'b0;
    localparam logic MODE_SERVICE = 1'b1;

    // Step durations in ticks.
    localparam logic [7:0] BLIP_TICKS       = 8'd10;
    localparam logic [7:0] DOUBLE_GAP_TICKS = 8'd200;
    localparam logic [7:0] SLOW_ON_TICKS    = 8'd180;
    localparam logic [7:0] SLOW_OFF_TICKS   = 8'd50;
    localparam logic [7:0] ONCE_ON_TICKS    = 8'd30;
    localparam logic [7:0] ONCE_OFF_TICKS   = 8'd20;

    typedef logic [TICK_BITS-1:0] tick_t;

    // One accepted input item.
    typedef struct packed {
        logic                mode;
        logic [2:0]          pattern;
        logic [NOW_BITS-1:0] now;
    } item_t;

    // One result item.
    typedef struct packed {
        logic       led_on;
        logic [2:0] active_pattern;
    } result_t;

    // What the step table gives for the current step of a blink pattern.
    typedef struct packed {
        logic [1:0] index;
        logic       level;
        logic [7:0] ticks;
        logic       last;
    } step_info_t;

    // Looks up the step in force; the raw step index is folded onto the
    // pattern's own step count first.
    function automatic step_info_t step_lookup(input logic [2:0] pat, input logic [1:0] step);
        step_info_t info;
        info = '0;
        case (pat)
            PAT_DOUBLE:
            begin
                info.index = step;
                info.level = ~step[0];
                info.ticks = (step == 2'd3) ? DOUBLE_GAP_TICKS : BLIP_TICKS;
                info.last  = (step == 2'd3);
            end
            PAT_FAST:
            begin
                info.index = {1'b0, step[0]};
                info.level = ~step[0];
                info.ticks = BLIP_TICKS;
                info.last  = step[0];
            end
            PAT_SLOW:
            begin
                info.index = {1'b0, step[0]};
                info.level = ~step[0];
                info.ticks = step[0] ? SLOW_OFF_TICKS : SLOW_ON_TICKS;
                info.last  = step[0];
            end
            PAT_ONCE:
            begin
                info.index = {1'b0, step[0]};
                info.level = ~step[0];
                info.ticks = step[0] ? ONCE_OFF_TICKS : ONCE_ON_TICKS;
                info.last  = step[0];
            end
            default:
            begin
                info = '0;
            end
        endcase
        return info;
    endfunction

endpackage

@@ rtl/led_blink_pattern_sequencer_unit.sv @@
// Top level of the LED blink pattern sequencer.
// One item is taken per clock when the result side keeps up: an item is held
// in the input register, where a single compare, add and step-table lookup update the
// pattern state, and its result is then held in the output register until taken, so
// sustained throughput is one item per cycle. A select item (mode 0) chooses the
// pattern, a service item (mode 1) carries the tick count; every item gives exactly
// one result with the LED level and the pattern in force after it.
module led_blink_pattern_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [2:0]  pattern,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        led_on,
    output logic [2:0]  active_pattern
);
    import lbps_pkg::*;

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    advance;
    result_t result;
    result_t out_result;

    assign in_item.mode    = mode;
    assign in_item.pattern = pattern;
    assign in_item.now     = now;

    // Input register.
    lbps_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // Pattern state and update.
    lbps_pattern_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (held_item),
        .result (result)
    );

    // Output register.
    lbps_output_stage u_output (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign led_on         = out_result.led_on;
    assign active_pattern = out_result.active_pattern;

endmodule

@@ rtl/lbps_input_stage.sv @@
// Input register of the LED blink sequencer: holds one accepted item.
module lbps_input_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  lbps_pkg::item_t in_item,
    input  logic           advance,
    output logic           held_valid,
    output lbps_pkg::item_t held_item
);
    import lbps_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    logic  load;

    // The register is free when empty or when its item moves on this cycle.
    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Item payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ rtl/lbps_pattern_engine.sv @@
// Pattern state of the LED blink sequencer and its per-item update.
module lbps_pattern_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  lbps_pkg::item_t   item,
    output lbps_pkg::result_t result
);
    import lbps_pkg::*;

`include "led_blink_pattern_sequencer_unit_macros.svh"

    logic [2:0] pattern_reg, pattern_next;
    logic [1:0] step_reg, step_next;
    tick_t      due_reg, due_next;
    logic       led_reg, led_next;

    logic [2:0] sel_pattern;
    tick_t      tick;
    step_info_t info;

    // Unused selector codes fall back to keep off.
    assign sel_pattern = (item.pattern > PAT_ONCE) ? PAT_KEEP_OFF : item.pattern;
    assign tick        = TICK_BITS'(item.now);
    assign info        = step_lookup(pattern_reg, step_reg);

    // Next state for the item in the input register.
    always_comb
    begin
        pattern_next = pattern_reg;
        step_next    = step_reg;
        due_next     = due_reg;
        led_next     = led_reg;
        if (item.mode == MODE_SELECT)
        begin
            if (sel_pattern != pattern_reg)
            begin
                pattern_next = sel_pattern;
                if (sel_pattern >= PAT_DOUBLE)
                begin
                    step_next = 2'd0;
                end
            end
        end
        else if (pattern_reg == PAT_KEEP_ON)
        begin
            led_next = 1'b1;
        end
        else if (pattern_reg == PAT_KEEP_OFF || pattern_reg > PAT_ONCE)
        begin
            led_next = 1'b0;
        end
        else if (tick > due_reg)
        begin
            led_next = info.level;
            due_next = tick + TICK_BITS'(info.ticks);
            if (info.last && pattern_reg == PAT_ONCE)
            begin
                pattern_next = PAT_KEEP_OFF;
                step_next    = info.index;
            end
            else if (info.last)
            begin
                step_next = 2'd0;
            end
            else
            begin
                step_next = info.index + 2'd1;
            end
        end
    end

    // The result shows the state after this item.
    assign result.led_on         = led_next;
    assign result.active_pattern = pattern_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= PAT_KEEP_OFF;
            step_reg    <= 2'd0;
            due_reg     <= '0;
            led_reg     <= 1'b0;
        end
        else if (fire)
        begin
            pattern_reg <= pattern_next;
            step_reg    <= step_next;
            due_reg     <= due_next;
            led_reg     <= led_next;
        end
    end

    // The pattern in force is always a meaningful code.
    `LBPS_ASSERT_NOW(a_pattern_legal, clk, rst_n, 1'b1, pattern_reg <= PAT_ONCE)
    // A select item never moves the LED.
    `LBPS_ASSERT_NEXT(a_select_keeps_led, clk, rst_n,
        fire && item.mode == MODE_SELECT, $stable(led_reg))
    // Servicing keep on lights the LED.
    `LBPS_ASSERT_NEXT(a_keep_on_lit, clk, rst_n,
        fire && item.mode == MODE_SERVICE && pattern_reg == PAT_KEEP_ON, led_reg)
    // Servicing a keep pattern leaves step index and due time alone.
    `LBPS_ASSERT_NEXT(a_keep_holds_step, clk, rst_n,
        fire && item.mode == MODE_SERVICE
            && (pattern_reg == PAT_KEEP_OFF || pattern_reg == PAT_KEEP_ON),
        $stable(step_reg) && $stable(due_reg))

endmodule

@@ rtl/lbps_output_stage.sv @@
// Output register of the LED blink sequencer: holds one result until taken.
module lbps_output_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             held_valid,
    input  lbps_pkg::result_t result,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_stall,
    output lbps_pkg::result_t out_result
);
    import lbps_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // An item moves on when the register is empty or is being emptied.
    assign advance    = held_valid && (!valid_reg || !out_stall);
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

endmodule
